// ===== src/lru_key_value_cache_defines.svh =====
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Same-cycle implication
`define LKV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LKV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lkv_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Field widths, operation codes, controller states and the per-cell control.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  // Capacity register after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Read value returned on a lookup miss
  localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_UPDATE = 1'b1
  } state_t;

  // Control for one cell of the recency chain
  typedef struct packed {
    logic cmp;    // latch key compare result
    logic shift;  // take the neighbor's entry
    logic evict;  // drop the entry (after shift)
  } cell_ctl_t;

endpackage

// ===== src/lkv_cell.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache cell
// One slot of the recency chain: holds key, value and valid, compares its key
// against a lookup and takes its more recent neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module lkv_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lkv_pkg::cell_ctl_t            ctl,
  input  logic [lkv_pkg::KEY_W-1:0]     cmp_key,
  input  logic [lkv_pkg::KEY_W-1:0]     prev_key,
  input  logic [lkv_pkg::VAL_W-1:0]     prev_value,
  input  logic                          prev_valid,
  output logic [lkv_pkg::KEY_W-1:0]     key,
  output logic [lkv_pkg::VAL_W-1:0]     value,
  output logic                          valid,
  output logic                          match
);

  logic [lkv_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [lkv_pkg::VAL_W-1:0] value_r, value_nxt;
  logic                      valid_r, valid_nxt;
  logic                      match_r, match_nxt;

  // Compare on lookup, hold otherwise
  always_comb begin
    match_nxt = match_r;
    if (ctl.cmp) begin
      match_nxt = valid_r && (key_r == cmp_key);
    end
  end

  // Shift in from the neighbor, then drop if evicted
  always_comb begin
    key_nxt   = key_r;
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctl.shift) begin
      key_nxt   = prev_key;
      value_nxt = prev_value;
      valid_nxt = prev_valid;
    end
    if (ctl.evict) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign key   = key_r;
  assign value = value_r;
  assign valid = valid_r;
  assign match = match_r;

endmodule

// ===== src/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative get/put store kept in recency order in a chain of cells.
// ----------------------------------------------------------------------------
// Each item has an accept cycle and an update state: in the accept cycle every
// cell compares its key and registers the result; in the next cycle the hit
// position is spread down the chain, the cells shift toward the least recent
// end and slot 0 takes the most recent entry. A get waits in the update state
// only while the previous result beat is still held on the output. A new item
// is taken while a result waits. Gets return one beat (tuser = hit, tdata =
// value or all ones on a miss); puts return none. Entries beyond a lowered
// capacity stay readable until the next inserting put.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache #(
  parameter int CAPACITY = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration: capacity_in_use
  input  logic                            cfg_wr_en,
  input  logic [lkv_pkg::CAP_W-1:0]       cfg_wr_data,
  // Request stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [63:0]                     in_tdata,   // [31:0] key, [63:32] value
  input  logic [0:0]                      in_tuser,   // [0] operation (0 get, 1 put)
  // Result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [31:0]                     out_tdata,  // [31:0] read_value
  output logic [0:0]                      out_tuser   // [0] hit
);

  logic [lkv_pkg::CAP_W-1:0] cap_r;

  lkv_pkg::state_t state_r, state_nxt;

  lkv_pkg::op_t              req_op_r;
  logic [lkv_pkg::KEY_W-1:0] req_key_r;
  logic [lkv_pkg::VAL_W-1:0] req_value_r;

  logic                      out_valid_r, out_valid_nxt;
  logic                      out_hit_r;
  logic [lkv_pkg::VAL_W-1:0] out_data_r;

  logic                      in_acc;
  logic                      commit;
  logic                      any_hit;
  logic                      put_miss;
  logic                      slot_free;
  logic [lkv_pkg::VAL_W-1:0] hit_value;
  logic [lkv_pkg::VAL_W-1:0] front_value;

  logic [CAPACITY-1:0]       match_vec;
  logic [CAPACITY-1:0]       valid_vec;
  logic [CAPACITY-1:0]       beyond;
  logic [lkv_pkg::KEY_W-1:0] key_q   [CAPACITY];
  logic [lkv_pkg::VAL_W-1:0] value_q [CAPACITY];
  lkv_pkg::cell_ctl_t        ctl     [CAPACITY];

  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign any_hit   = |match_vec;
  assign put_miss  = (req_op_r == lkv_pkg::OP_PUT) && !any_hit;

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lkv_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lkv_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = lkv_pkg::ST_UPDATE;
        end
      end
      lkv_pkg::ST_UPDATE: begin
        if (req_op_r == lkv_pkg::OP_PUT || slot_free) begin
          state_nxt = lkv_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lkv_pkg::ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_tready = 1'b0;
    commit    = 1'b0;
    unique case (state_r)
      lkv_pkg::ST_IDLE: begin
        in_tready = 1'b1;
      end
      lkv_pkg::ST_UPDATE: begin
        commit = (req_op_r == lkv_pkg::OP_PUT) || slot_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lkv_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_op_r <= lkv_pkg::OP_GET;
    end else if (in_acc) begin
      req_op_r <= lkv_pkg::op_t'(in_tuser[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_key_r   <= in_tdata[31:0];
      req_value_r <= in_tdata[63:32];
    end
  end

  // Select the matching cell's value (at most one cell matches)
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_value = hit_value | (value_q[i] & {lkv_pkg::VAL_W{match_vec[i]}});
    end
  end

  assign front_value = (req_op_r == lkv_pkg::OP_PUT) ? req_value_r : hit_value;

  // Recency chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [lkv_pkg::KEY_W-1:0] prev_key;
    logic [lkv_pkg::VAL_W-1:0] prev_value;
    logic                      prev_valid;
    logic                      evict_pos;

    // Cells at or past the capacity drop out on an insert; slot 0 never does
    if (i == 0) begin : g_front
      assign prev_key   = req_key_r;
      assign prev_value = front_value;
      assign prev_valid = 1'b1;
      assign evict_pos  = 1'b0;
    end else begin : g_body
      assign prev_key   = key_q[i-1];
      assign prev_value = value_q[i-1];
      assign prev_valid = valid_vec[i-1];
      assign evict_pos  = (cap_r == '0) || (32'(cap_r) <= 32'(i));
    end

    // Shift every cell from the front down to the hit
    assign beyond[i] = |match_vec[CAPACITY-1:i];

    assign ctl[i].cmp   = in_acc;
    assign ctl[i].shift = commit && (put_miss || beyond[i]);
    assign ctl[i].evict = commit && put_miss && evict_pos;

    lkv_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl[i]),
      .cmp_key    (in_tdata[31:0]),
      .prev_key   (prev_key),
      .prev_value (prev_value),
      .prev_valid (prev_valid),
      .key        (key_q[i]),
      .value      (value_q[i]),
      .valid      (valid_vec[i]),
      .match      (match_vec[i])
    );
  end

  // Result register: load on a committed get, drop on a taken beat
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tvalid && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (commit && req_op_r == lkv_pkg::OP_GET) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && req_op_r == lkv_pkg::OP_GET) begin
      out_hit_r  <= any_hit;
      out_data_r <= any_hit ? hit_value : lkv_pkg::MISS_VALUE;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_hit_r;

  // Valid entries stay packed toward slot 0
  `LKV_ASSERT_IMP(a_valid_packed, 1'b1, ((valid_vec >> 1) & ~valid_vec) == '0, "valid gap in chain")
  // Keys are unique, so a lookup hits at most one cell
  `LKV_ASSERT_IMP(a_match_single, state_r == lkv_pkg::ST_UPDATE, $onehot0(match_vec), "multiple key matches")
  // A committed get leaves a result beat
  `LKV_ASSERT_NXT(a_get_result, commit && req_op_r == lkv_pkg::OP_GET, out_valid_r, "get result lost")
  // After any committed put slot 0 holds a valid entry
  `LKV_ASSERT_NXT(a_put_front, commit && req_op_r == lkv_pkg::OP_PUT, valid_vec[0], "put left slot 0 empty")

endmodule

// ===== sim/lru_key_value_cache_test.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Drives get and put beats into the cache, predicts every lookup answer with
// a software copy of the recency-ordered store, and checks each result beat
// against it. Directed cases cover key and value extremes, updates, eviction
// order and a lowered capacity. Random traffic then runs over a sweep of
// capacity settings with random stalls on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_key_value_cache_test;

  localparam int CACHE_DEPTH   = 16;
  localparam int MAX_REPORTS   = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_COUNT   = 10;
  localparam int PHASE_ITEMS   = 165;

  typedef struct packed {
    logic                      hit;
    logic [lkv_pkg::VAL_W-1:0] value;
  } lookup_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_wr_en;
  logic [lkv_pkg::CAP_W-1:0] cfg_wr_data;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [63:0]               in_tdata;   // [31:0] key, [63:32] value
  logic [0:0]                in_tuser;   // [0] operation
  logic                      out_tvalid;
  logic                      out_tready;
  logic [31:0]               out_tdata;  // [31:0] read_value
  logic [0:0]                out_tuser;  // [0] hit

  // Predicted store, slot 0 most recent
  logic [lkv_pkg::KEY_W-1:0] cache_keys  [CACHE_DEPTH];
  logic [lkv_pkg::VAL_W-1:0] cache_vals  [CACHE_DEPTH];
  logic                      cache_valid [CACHE_DEPTH];
  logic [lkv_pkg::CAP_W-1:0] capacity_reg;

  lookup_t                   pending_lookups[$];
  logic [lkv_pkg::KEY_W-1:0] key_pool[$];

  int idle_max;
  int items_sent;
  int lookups_checked;
  int mismatch_count;
  int cap_writes;

  lru_key_value_cache #(
    .CAPACITY(CACHE_DEPTH)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Clamp the register to the range the store honors
  function automatic int effective_capacity();
    int c;
    c = capacity_reg;
    if (c < 1) c = 1;
    if (c > CACHE_DEPTH) c = CACHE_DEPTH;
    return c;
  endfunction

  function automatic int find_slot(logic [lkv_pkg::KEY_W-1:0] key);
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      if (cache_valid[i] && cache_keys[i] == key) return i;
    end
    return -1;
  endfunction

  // Move one entry to the most recent slot, push the newer ones down
  function automatic void promote_slot(int pos);
    logic [lkv_pkg::KEY_W-1:0] k;
    logic [lkv_pkg::VAL_W-1:0] v;
    k = cache_keys[pos];
    v = cache_vals[pos];
    for (int i = pos; i > 0; i--) begin
      cache_keys[i]  = cache_keys[i-1];
      cache_vals[i]  = cache_vals[i-1];
      cache_valid[i] = cache_valid[i-1];
    end
    cache_keys[0]  = k;
    cache_vals[0]  = v;
    cache_valid[0] = 1'b1;
  endfunction

  // Apply one accepted request; queue the answer of a get
  function automatic void cache_model_step(lkv_pkg::op_t op,
                                           logic [lkv_pkg::KEY_W-1:0] key,
                                           logic [lkv_pkg::VAL_W-1:0] value);
    int      pos;
    int      cap;
    lookup_t answer;
    pos = find_slot(key);
    if (op == lkv_pkg::OP_GET) begin
      if (pos >= 0) begin
        promote_slot(pos);
        answer.hit   = 1'b1;
        answer.value = cache_vals[0];
      end else begin
        answer.hit   = 1'b0;
        answer.value = lkv_pkg::MISS_VALUE;
      end
      pending_lookups.push_back(answer);
    end else if (pos >= 0) begin
      promote_slot(pos);
      cache_vals[0] = value;
    end else begin
      for (int i = CACHE_DEPTH - 1; i > 0; i--) begin
        cache_keys[i]  = cache_keys[i-1];
        cache_vals[i]  = cache_vals[i-1];
        cache_valid[i] = cache_valid[i-1];
      end
      cache_keys[0]  = key;
      cache_vals[0]  = value;
      cache_valid[0] = 1'b1;
      cap = effective_capacity();
      for (int i = cap; i < CACHE_DEPTH; i++) cache_valid[i] = 1'b0;
    end
  endfunction

  // Send one request beat after a random gap, predict it once accepted
  task automatic send_request(lkv_pkg::op_t op, logic [lkv_pkg::KEY_W-1:0] key,
                              logic [lkv_pkg::VAL_W-1:0] value);
    int gap;
    gap = (idle_max > 0) ? $urandom_range(0, idle_max) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {value, key};
    do @(posedge clk); while (!in_tready);
    cache_model_step(op, key, value);
    items_sent++;
  endtask

  // Hold off input until every answer is back and the update cycle is over
  task automatic wait_until_drained();
    in_tvalid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [lkv_pkg::CAP_W-1:0] cap);
    wait_until_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    capacity_reg = cap;
    cap_writes++;
  endtask

  // Empty lookup, key and value extremes, one-bit key difference, update
  task automatic test_lookup_extremes();
    send_request(lkv_pkg::OP_GET, 32'h0000_0000, 32'h5A5A_5A5A);
    send_request(lkv_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(lkv_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(lkv_pkg::OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(lkv_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0000);
    send_request(lkv_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(lkv_pkg::OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(lkv_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(lkv_pkg::OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(lkv_pkg::OP_GET, 32'h0000_0001, 32'h0000_0000);
    send_request(lkv_pkg::OP_GET, 32'h7FFF_FFFE, 32'h0000_0000);
    send_request(lkv_pkg::OP_PUT, 32'h8000_0000, 32'h1234_5678);
    send_request(lkv_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
  endtask

  // Least recent goes first; a lowered capacity keeps old entries readable
  task automatic test_eviction_order();
    write_capacity(5'd4);
    send_request(lkv_pkg::OP_PUT, 32'h0000_00A0, 32'h0000_0001);
    send_request(lkv_pkg::OP_PUT, 32'h0000_00B0, 32'h0000_0002);
    send_request(lkv_pkg::OP_PUT, 32'h0000_00C0, 32'h0000_0003);
    send_request(lkv_pkg::OP_PUT, 32'h0000_00D0, 32'h0000_0004);
    send_request(lkv_pkg::OP_GET, 32'h0000_00A0, 32'h0000_0000);
    send_request(lkv_pkg::OP_PUT, 32'h0000_00E0, 32'h0000_0005);
    send_request(lkv_pkg::OP_GET, 32'h0000_00B0, 32'h0000_0000);
    write_capacity(5'd1);
    send_request(lkv_pkg::OP_GET, 32'h0000_00C0, 32'h0000_0000);
    send_request(lkv_pkg::OP_PUT, 32'h0000_00F0, 32'h0000_0006);
    send_request(lkv_pkg::OP_GET, 32'h0000_00A0, 32'h0000_0000);
    send_request(lkv_pkg::OP_GET, 32'h0000_00F0, 32'h0000_0000);
  endtask

  // Random gets and puts, mostly over a pool of keys sized near the capacity
  task automatic test_random_traffic(logic [lkv_pkg::CAP_W-1:0] cap, int count,
                                     int idle_setting);
    int                        eff;
    int                        target;
    lkv_pkg::op_t              op;
    logic [lkv_pkg::KEY_W-1:0] key;
    write_capacity(cap);
    idle_max = idle_setting;
    eff = effective_capacity();
    target = eff + $urandom_range(1, 4);
    // keep a few keys of the last phase so stale entries get looked up
    while (key_pool.size() > eff / 2 + 1) void'(key_pool.pop_front());
    while (key_pool.size() < target) key_pool.push_back($urandom);
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) wait_until_drained();
      op  = lkv_pkg::op_t'($urandom_range(0, 1));
      key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, key_pool.size() - 1)]
                                         : $urandom;
      send_request(op, key, $urandom);
    end
  endtask

  // Accept result beats with random stalls, compare with the oldest answer
  initial begin : result_checker
    lookup_t want;
    int      stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (pending_lookups.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("ERROR: result beat with no request waiting: hit=%0b value=%h",
                     out_tuser[0], out_tdata);
        end else begin
          want = pending_lookups.pop_front();
          lookups_checked++;
          if (out_tuser[0] !== want.hit || out_tdata !== want.value) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("ERROR: lookup %0d: expected hit=%0b value=%h, got hit=%0b value=%h",
                       lookups_checked, want.hit, want.value, out_tuser[0], out_tdata);
          end
        end
        stall = (idle_max > 0) ? $urandom_range(0, idle_max) : 0;
        if (stall > 0) out_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        if (stall == 0) out_tready <= 1'b1;
      end
    end
  end

  initial begin : main_sequence
    logic [lkv_pkg::CAP_W-1:0] phase_caps [PHASE_COUNT];
    int                        phase_idle [PHASE_COUNT];
    int                        wait_cycles;
    phase_caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd8, 5'd2, 5'd12, 5'd16, 5'd3};
    phase_idle = '{15, 15, 15, 0, 15, 15, 0, 15, 15, 15};
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    out_tready  <= 1'b1;
    idle_max        = 15;
    items_sent      = 0;
    lookups_checked = 0;
    mismatch_count  = 0;
    cap_writes      = 0;
    capacity_reg    = lkv_pkg::CAP_RESET;
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      cache_keys[i]  = '0;
      cache_vals[i]  = '0;
      cache_valid[i] = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_lookup_extremes();
    test_eviction_order();
    for (int p = 0; p < PHASE_COUNT; p++)
      test_random_traffic(phase_caps[p], PHASE_ITEMS, phase_idle[p]);

    // Drain the last answers, then watch for stray beats
    in_tvalid <= 1'b0;
    wait_cycles = 0;
    while (pending_lookups.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_lookups.size() != 0) begin
      $display("ERROR: %0d lookups never answered", pending_lookups.size());
      mismatch_count += pending_lookups.size();
    end

    $display("Sent %0d requests over %0d capacity settings, checked %0d lookup answers.",
             items_sent, cap_writes, lookups_checked);
    $display("Mismatches found: %0d", mismatch_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog far above the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("ERROR: timeout");
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/lkv_pkg.sv
src/lkv_cell.sv
src/lru_key_value_cache.sv
sim/lru_key_value_cache_test.sv
